[hw/rtl/discount_curve_interpolator_top_assert.svh]
// assertion helpers for the top level
`ifndef DISCOUNT_CURVE_INTERPOLATOR_TOP_ASSERT_SVH
`define DISCOUNT_CURVE_INTERPOLATOR_TOP_ASSERT_SVH

// same-cycle implication
`define DCI_ASSERT_IMP(LBL, PRE, CON, MSG) \
  LBL: assert property (@(posedge clk) disable iff (!rst_n) (PRE) |-> (CON)) \
    else $error(MSG);

// next-cycle implication
`define DCI_ASSERT_NXT(LBL, PRE, CON, MSG) \
  LBL: assert property (@(posedge clk) disable iff (!rst_n) (PRE) |=> (CON)) \
    else $error(MSG);

`endif

[hw/rtl/dci_pkg.sv]
package dci_pkg;

  localparam int MAX_KNOTS_DEF     = 32;
  localparam int DAYS_PER_YEAR_DEF = 360;

  localparam int DIV_NW = 78;
  localparam int DIV_DW = 46;

  localparam logic [31:0]     ONE_Q30  = 32'h4000_0000;
  localparam logic [31:0]     OUT_MAX  = 32'hFFFF_FFFF;
  localparam logic [DIV_NW:0] TERM_CAP = (DIV_NW + 1)'(1) << 60;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_RATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_ASC   = 2'd3
  } status_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DIV_NW:0] quo;
  } div_rsp_t;

endpackage

[hw/rtl/dci_div.sv]
module dci_div (
  input  logic               clk,
  input  logic               rst_n,
  input  dci_pkg::div_req_t  req,
  output dci_pkg::div_rsp_t  rsp
);

  localparam int NW = dci_pkg::DIV_NW;
  localparam int DW = dci_pkg::DIV_DW;
  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          fin_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   rem_r;
  logic [NW-1:0] quo_r;
  logic [NW:0]   res_r;

  logic [DW:0] rem_sh;
  logic        ge;
  logic [DW:0] rem_nxt;
  logic        round_up;

  always_comb begin
    rem_sh   = {rem_r[DW-1:0], num_r[NW-1]};
    ge       = rem_sh >= {1'b0, den_r};
    rem_nxt  = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
    round_up = {rem_r[DW-1:0], 1'b0} >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        num_r <= num_r << 1;
        quo_r <= {quo_r[NW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        res_r  <= {1'b0, quo_r} + (NW + 1)'(round_up);
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = res_r;

endmodule

[hw/rtl/discount_curve_interpolator_top.sv]
// channel   ports                                     transfer
// command   start, busy, in_*                         start high while busy low
// result    out_valid, out_factor_q30, out_status     out_valid, one cycle, no stall
// config    cfg_we, cfg_wdata                         cfg_we high
//
// clear, refused add and unused command: result registered in the cycle after transfer
// add: multiply, denominator, 78-step restoring divide (none if denominator <= 0)
// query: a read and a compare per knot scanned, load the window, then one divide
//   (linear) or up to six divides (quadratic)
// synchronous active-low reset; knot 0 is fixed logic, no clearing pass
module discount_curve_interpolator_top #(
  parameter int MAX_KNOTS     = dci_pkg::MAX_KNOTS_DEF,
  parameter int DAYS_PER_YEAR = dci_pkg::DAYS_PER_YEAR_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [14:0]        in_quote_maturity_days,
  input  logic signed [27:0] in_quote_rate_micro_pct,
  input  logic [22:0]        in_query_day_q8,
  output logic               out_valid,
  output logic [31:0]        out_factor_q30,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  localparam int AW   = $clog2(MAX_KNOTS);
  localparam int CNTW = $clog2(MAX_KNOTS + 1);
  localparam int NW   = dci_pkg::DIV_NW;
  localparam int DW   = dci_pkg::DIV_DW;
  localparam logic [36:0] NQ = 37'(DAYS_PER_YEAR) * 37'd100000000;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD_MUL, S_ADD_DEN, S_DIV_GO, S_DIV,
    S_Q_START, S_Q_LAST_RD, S_Q_LAST_USE, S_Q_SCAN_RD, S_Q_SCAN_CMP,
    S_W_RD, S_W_CAP, S_W_EVAL, S_T_MUL, S_T_PLO, S_T_PHI, S_QF
  } state_t;

  typedef enum logic [1:0] {OP_ADD, OP_LIN, OP_TERM} op_t;

  state_t state_r;
  op_t    op_r;

  logic                 mode_r;
  logic [CNTW-1:0]      cnt_r;
  logic [14:0]          last_day_r;
  logic [22:0]          t_r;
  logic [14:0]          days_r;
  logic signed [27:0]   rate_r;
  logic [AW-1:0]        j_r;
  logic [2:0]           m_r;
  logic [22:0]          wx_r [4];
  logic [31:0]          wy_r [4];
  logic                 pb_r;
  logic                 pend_r;
  logic                 both_r;
  logic [1:0]           k_r;
  logic signed [47:0]   nm_r;
  logic signed [47:0]   dn_r;
  logic [NW-1:0]        p_r;
  logic [DW-1:0]        dden_r;
  logic                 neg_r;
  logic signed [63:0]   acc_r;
  logic signed [43:0]   prod_r;
  logic                 ov_r;
  logic [31:0]          of_r;
  logic [1:0]           os_r;

  logic                 mem_we_r;
  logic [AW-1:0]        wr_addr_r;
  logic [14:0]          wr_day_r;
  logic [31:0]          wr_fac_r;
  logic [14:0]          knot_day_mem [MAX_KNOTS];
  logic [31:0]          knot_factor_mem [MAX_KNOTS];
  logic [AW-1:0]        rd_addr;
  logic                 rd_zero_r;
  logic [14:0]          rd_day_r;
  logic [31:0]          rd_fac_r;
  logic [14:0]          rd_day;
  logic [31:0]          rd_fac;

  dci_pkg::div_req_t    div_req;
  dci_pkg::div_rsp_t    div_rsp;

  logic [AW+1:0]        wi;
  logic                 wi_ok;
  logic [1:0]           ia, ib, ic;
  logic [22:0]          xa, xb, xc;
  logic [31:0]          ya;
  logic signed [23:0]   da1, da2, dd1, dd2;
  logic [47:0]          nmag;
  logic [47:0]          dmag;
  logic [54:0]          mul_lo, mul_hi;
  logic [32:0]          dy;
  logic [31:0]          dymag;
  logic [22:0]          dt, dx;
  logic [54:0]          lin_mul;
  logic signed [43:0]   add_prod;
  logic signed [44:0]   add_den;
  logic [NW:0]          quo;
  logic [60:0]          mcap;
  logic signed [63:0]   term;
  logic signed [34:0]   lin_res;
  logic signed [63:0]   half;
  logic signed [63:0]   qval;
  logic [31:0]          qclamp;

  always_comb begin
    rd_day = rd_zero_r ? 15'd0 : rd_day_r;
    rd_fac = rd_zero_r ? dci_pkg::ONE_Q30 : rd_fac_r;
    wi     = (AW + 2)'(j_r) + (AW + 2)'(m_r) - (AW + 2)'(2);
    wi_ok  = !wi[AW+1] && (wi[AW:0] < (AW + 1)'(cnt_r));
    case (state_r)
      S_Q_SCAN_RD: rd_addr = j_r;
      S_Q_LAST_RD: rd_addr = AW'(cnt_r - 1'b1);
      S_W_RD:      rd_addr = wi[AW-1:0];
      default:     rd_addr = '0;
    endcase
  end

  always_comb begin
    ia   = {1'b0, pb_r} + k_r;
    ib   = {1'b0, pb_r} + ((k_r == 2'd0) ? 2'd1 : 2'd0);
    ic   = {1'b0, pb_r} + ((k_r == 2'd2) ? 2'd1 : 2'd2);
    xa   = wx_r[ia];
    xb   = wx_r[ib];
    xc   = wx_r[ic];
    ya   = wy_r[ia];
    da1  = $signed({1'b0, t_r}) - $signed({1'b0, xb});
    da2  = $signed({1'b0, t_r}) - $signed({1'b0, xc});
    dd1  = $signed({1'b0, xa}) - $signed({1'b0, xb});
    dd2  = $signed({1'b0, xa}) - $signed({1'b0, xc});
    nmag = nm_r[47] ? 48'(-nm_r) : 48'(nm_r);
    dmag = dn_r[47] ? 48'(-dn_r) : 48'(dn_r);
    mul_lo = ya * nmag[22:0];
    mul_hi = ya * nmag[45:23];
    dy     = {1'b0, wy_r[2]} - {1'b0, wy_r[1]};
    dymag  = dy[32] ? 32'(-dy) : dy[31:0];
    dt     = t_r - wx_r[1];
    dx     = wx_r[2] - wx_r[1];
    lin_mul  = dymag * dt;
    add_prod = rate_r * $signed({1'b0, days_r});
    add_den  = $signed({8'd0, NQ}) + 45'(prod_r);
    quo      = div_rsp.quo;
    mcap     = (quo > dci_pkg::TERM_CAP) ? dci_pkg::TERM_CAP[60:0] : quo[60:0];
    term     = neg_r ? -$signed(64'(mcap)) : $signed(64'(mcap));
    lin_res  = neg_r ? ($signed(35'(wy_r[1])) - $signed(35'(quo[33:0])))
                     : ($signed(35'(wy_r[1])) + $signed(35'(quo[33:0])));
    half     = acc_r[63] ? -((-acc_r + 64'sd1) >>> 1) : ((acc_r + 64'sd1) >>> 1);
    qval     = both_r ? half : acc_r;
    if (qval[63]) begin
      qclamp = 32'd0;
    end else if (qval[62:32] != '0) begin
      qclamp = dci_pkg::OUT_MAX;
    end else begin
      qclamp = qval[31:0];
    end
  end

  assign div_req.start = (state_r == S_DIV_GO);
  assign div_req.num   = p_r;
  assign div_req.den   = dden_r;

  dci_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (mem_we_r) begin
      knot_day_mem[wr_addr_r]    <= wr_day_r;
      knot_factor_mem[wr_addr_r] <= wr_fac_r;
    end
    rd_day_r  <= knot_day_mem[rd_addr];
    rd_fac_r  <= knot_factor_mem[rd_addr];
    rd_zero_r <= (rd_addr == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      op_r       <= OP_ADD;
      mode_r     <= 1'b0;
      cnt_r      <= CNTW'(1);
      last_day_r <= '0;
      ov_r       <= 1'b0;
      mem_we_r   <= 1'b0;
    end else begin
      ov_r     <= 1'b0;
      mem_we_r <= 1'b0;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            t_r    <= in_query_day_q8;
            days_r <= in_quote_maturity_days;
            rate_r <= in_quote_rate_micro_pct;
            case (in_command)
              dci_pkg::CMD_CLEAR: begin
                cnt_r      <= CNTW'(1);
                last_day_r <= '0;
                ov_r       <= 1'b1;
                of_r       <= dci_pkg::ONE_Q30;
                os_r       <= dci_pkg::ST_OK;
              end
              dci_pkg::CMD_ADD: begin
                if (in_quote_rate_micro_pct == '0) begin
                  ov_r <= 1'b1;
                  of_r <= '0;
                  os_r <= dci_pkg::ST_ZERO_RATE;
                end else if (cnt_r >= CNTW'(MAX_KNOTS)) begin
                  ov_r <= 1'b1;
                  of_r <= '0;
                  os_r <= dci_pkg::ST_FULL;
                end else if (in_quote_maturity_days <= last_day_r) begin
                  ov_r <= 1'b1;
                  of_r <= '0;
                  os_r <= dci_pkg::ST_NOT_ASC;
                end else begin
                  state_r <= S_ADD_MUL;
                end
              end
              dci_pkg::CMD_QUERY: begin
                state_r <= S_Q_START;
              end
              default: begin
                ov_r <= 1'b1;
                of_r <= '0;
                os_r <= dci_pkg::ST_OK;
              end
            endcase
          end
        end
        S_ADD_MUL: begin
          prod_r  <= add_prod;
          state_r <= S_ADD_DEN;
        end
        S_ADD_DEN: begin
          if (add_den <= 45'sd0) begin
            mem_we_r   <= 1'b1;
            wr_addr_r  <= cnt_r[AW-1:0];
            wr_day_r   <= days_r;
            wr_fac_r   <= dci_pkg::OUT_MAX;
            cnt_r      <= cnt_r + 1'b1;
            last_day_r <= days_r;
            ov_r       <= 1'b1;
            of_r       <= dci_pkg::OUT_MAX;
            os_r       <= dci_pkg::ST_OK;
            state_r    <= S_IDLE;
          end else begin
            p_r     <= NW'(NQ) << 30;
            dden_r  <= DW'(add_den[43:0]);
            op_r    <= OP_ADD;
            state_r <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            case (op_r)
              OP_ADD: begin
                mem_we_r   <= 1'b1;
                wr_addr_r  <= cnt_r[AW-1:0];
                wr_day_r   <= days_r;
                wr_fac_r   <= (quo > (NW + 1)'(dci_pkg::OUT_MAX)) ? dci_pkg::OUT_MAX
                                                                  : quo[31:0];
                cnt_r      <= cnt_r + 1'b1;
                last_day_r <= days_r;
                ov_r       <= 1'b1;
                of_r       <= (quo > (NW + 1)'(dci_pkg::OUT_MAX)) ? dci_pkg::OUT_MAX
                                                                  : quo[31:0];
                os_r       <= dci_pkg::ST_OK;
                state_r    <= S_IDLE;
              end
              OP_LIN: begin
                ov_r    <= 1'b1;
                os_r    <= dci_pkg::ST_OK;
                if (lin_res[34]) begin
                  of_r <= '0;
                end else if (lin_res[33:32] != 2'b00) begin
                  of_r <= dci_pkg::OUT_MAX;
                end else begin
                  of_r <= lin_res[31:0];
                end
                state_r <= S_IDLE;
              end
              default: begin
                acc_r <= acc_r + term;
                if (k_r == 2'd2) begin
                  if (pb_r == pend_r) begin
                    state_r <= S_QF;
                  end else begin
                    pb_r    <= 1'b1;
                    k_r     <= 2'd0;
                    state_r <= S_T_MUL;
                  end
                end else begin
                  k_r     <= k_r + 1'b1;
                  state_r <= S_T_MUL;
                end
              end
            endcase
          end
        end
        S_Q_START: begin
          if (t_r == '0) begin
            ov_r    <= 1'b1;
            of_r    <= dci_pkg::ONE_Q30;
            os_r    <= dci_pkg::ST_OK;
            state_r <= S_IDLE;
          end else if (t_r >= {last_day_r, 8'd0}) begin
            state_r <= S_Q_LAST_RD;
          end else begin
            j_r     <= AW'(1);
            state_r <= S_Q_SCAN_RD;
          end
        end
        S_Q_LAST_RD: begin
          state_r <= S_Q_LAST_USE;
        end
        S_Q_LAST_USE: begin
          ov_r    <= 1'b1;
          of_r    <= rd_fac;
          os_r    <= dci_pkg::ST_OK;
          state_r <= S_IDLE;
        end
        S_Q_SCAN_RD: begin
          state_r <= S_Q_SCAN_CMP;
        end
        S_Q_SCAN_CMP: begin
          if (t_r <= {rd_day, 8'd0}) begin
            m_r     <= '0;
            state_r <= S_W_RD;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_Q_SCAN_RD;
          end
        end
        S_W_RD: begin
          if (m_r == 3'd4) begin
            state_r <= S_W_EVAL;
          end else if (wi_ok) begin
            state_r <= S_W_CAP;
          end else begin
            m_r <= m_r + 1'b1;
          end
        end
        S_W_CAP: begin
          wx_r[m_r[1:0]] <= {rd_day, 8'd0};
          wy_r[m_r[1:0]] <= rd_fac;
          m_r            <= m_r + 1'b1;
          state_r        <= S_W_RD;
        end
        S_W_EVAL: begin
          if (t_r == wx_r[2]) begin
            ov_r    <= 1'b1;
            of_r    <= wy_r[2];
            os_r    <= dci_pkg::ST_OK;
            state_r <= S_IDLE;
          end else if (!mode_r || (cnt_r < CNTW'(3))) begin
            p_r     <= NW'(lin_mul);
            dden_r  <= DW'(dx);
            neg_r   <= dy[32];
            op_r    <= OP_LIN;
            state_r <= S_DIV_GO;
          end else begin
            pb_r    <= !(j_r > AW'(1));
            pend_r  <= ((AW + 1)'(j_r) + (AW + 1)'(1)) < (AW + 1)'(cnt_r);
            both_r  <= (j_r > AW'(1)) &&
                       (((AW + 1)'(j_r) + (AW + 1)'(1)) < (AW + 1)'(cnt_r));
            k_r     <= 2'd0;
            acc_r   <= '0;
            op_r    <= OP_TERM;
            state_r <= S_T_MUL;
          end
        end
        S_T_MUL: begin
          nm_r    <= da1 * da2;
          dn_r    <= dd1 * dd2;
          state_r <= S_T_PLO;
        end
        S_T_PLO: begin
          p_r     <= NW'(mul_lo);
          neg_r   <= nm_r[47] ^ dn_r[47];
          dden_r  <= dmag[DW-1:0];
          state_r <= S_T_PHI;
        end
        S_T_PHI: begin
          p_r     <= p_r + {mul_hi, 23'd0};
          state_r <= S_DIV_GO;
        end
        S_QF: begin
          ov_r    <= 1'b1;
          of_r    <= qclamp;
          os_r    <= dci_pkg::ST_OK;
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = ov_r;
  assign out_factor_q30 = of_r;
  assign out_status     = os_r;

`include "discount_curve_interpolator_top_assert.svh"

  `DCI_ASSERT_NXT(a_query_busy, start && !busy && in_command == dci_pkg::CMD_QUERY, busy, "query transfer did not start work")
  `DCI_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r != '0 && cnt_r <= CNTW'(MAX_KNOTS), "knot count out of range")
  `DCI_ASSERT_IMP(a_div_done, div_rsp.done, state_r == S_DIV, "divider result outside wait state")
  `DCI_ASSERT_NXT(a_add_write, state_r == S_DIV && div_rsp.done && op_r == OP_ADD, out_valid && mem_we_r, "append without result or write")

endmodule

[test/discount_curve_interpolator_top_test.sv]
module discount_curve_interpolator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0]      factor;
    dci_pkg::status_t status;
  } curve_result_t;

  class curve_scoreboard;
    bit            mode;
    bit [14:0]     day[32];
    bit [31:0]     fac[32];
    int            count;
    curve_result_t pending_q[$];
    int            errors;

    function new();
      mode = 0;
      count = 1;
      day[0] = 0;
      fac[0] = dci_pkg::ONE_Q30;
      errors = 0;
    endfunction

    function bit [63:0] mul_div_rnd(bit [63:0] a, bit [63:0] b, bit [63:0] c);
      bit [127:0] p, q, r;
      p = {64'b0, a} * {64'b0, b};
      q = p / c;
      r = p % c;
      if (q > 128'hFFFF_FFFF_FFFF_FFFF) return 64'hFFFF_FFFF_FFFF_FFFF;
      if (r >= c - r) begin
        if (q == 128'hFFFF_FFFF_FFFF_FFFF) return q[63:0];
        q = q + 1;
      end
      return q[63:0];
    endfunction

    function bit [63:0] mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint term(bit [63:0] y, longint num, longint den);
      bit [63:0] m;
      m = mul_div_rnd(y, mag(num), mag(den));
      if (m > 64'd1 << 60) m = 64'd1 << 60;
      return ((num < 0) != (den < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function longint parabola(longint t, int a);
      longint x0, x1, x2;
      x0 = longint'(day[a]) * 256;
      x1 = longint'(day[a + 1]) * 256;
      x2 = longint'(day[a + 2]) * 256;
      return term(fac[a], (t - x1) * (t - x2), (x0 - x1) * (x0 - x2))
           + term(fac[a + 1], (t - x0) * (t - x2), (x1 - x0) * (x1 - x2))
           + term(fac[a + 2], (t - x0) * (t - x1), (x2 - x0) * (x2 - x1));
    endfunction

    function bit [31:0] clamp32(longint v);
      if (v < 0) return 0;
      if (v > longint'(dci_pkg::OUT_MAX)) return dci_pkg::OUT_MAX;
      return v[31:0];
    endfunction

    function bit [31:0] interp(longint t);
      int i;
      longint xi, xj, dy, inc, s, h;
      if (t <= longint'(day[0]) * 256) return fac[0];
      if (t >= longint'(day[count - 1]) * 256) return fac[count - 1];
      for (i = 0; i + 2 < count; i++)
        if (t <= longint'(day[i + 1]) * 256) break;
      xi = longint'(day[i]) * 256;
      xj = longint'(day[i + 1]) * 256;
      if (t == xi) return fac[i];
      if (t == xj) return fac[i + 1];
      if (!mode || count < 3) begin
        dy = longint'(fac[i + 1]) - longint'(fac[i]);
        inc = longint'(mul_div_rnd(mag(dy), t - xi, xj - xi));
        return clamp32(dy < 0 ? longint'(fac[i]) - inc : longint'(fac[i]) + inc);
      end
      if (i > 0 && i + 2 < count) begin
        s = parabola(t, i - 1) + parabola(t, i);
        h = s >= 0 ? (s + 1) / 2 : -((-s + 1) / 2);
        return clamp32(h);
      end
      if (i > 0) return clamp32(parabola(t, i - 1));
      return clamp32(parabola(t, i));
    endfunction

    function void note(dci_pkg::cmd_t c, int d, int r, int t);
      curve_result_t e;
      longint nq, dn;
      bit [63:0] f;
      e.factor = 0;
      e.status = dci_pkg::ST_OK;
      case (c)
        dci_pkg::CMD_CLEAR: begin
          count = 1;
          e.factor = dci_pkg::ONE_Q30;
        end
        dci_pkg::CMD_ADD: begin
          if (r == 0) e.status = dci_pkg::ST_ZERO_RATE;
          else if (count >= dci_pkg::MAX_KNOTS_DEF) e.status = dci_pkg::ST_FULL;
          else if (d <= day[count - 1]) e.status = dci_pkg::ST_NOT_ASC;
          else begin
            nq = longint'(dci_pkg::DAYS_PER_YEAR_DEF) * 100000000;
            dn = nq + longint'(r) * d;
            if (dn <= 0) e.factor = dci_pkg::OUT_MAX;
            else begin
              f = mul_div_rnd(nq, dci_pkg::ONE_Q30, dn);
              e.factor = f > dci_pkg::OUT_MAX ? dci_pkg::OUT_MAX : f[31:0];
            end
            day[count] = 15'(d);
            fac[count] = e.factor;
            count++;
          end
        end
        dci_pkg::CMD_QUERY: e.factor = interp(t);
        default: ;
      endcase
      pending_q.insert(pending_q.size(), e);
    endfunction

    function void check(logic [31:0] f, logic [1:0] s);
      curve_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result factor %h status %0d", f, s);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (f !== e.factor) begin
        $error("factor_q30 expected %h actual %h", e.factor, f);
        errors++;
      end
      if (s !== e.status) begin
        $error("status expected %0d actual %0d", e.status, s);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_command;
  logic [14:0]        in_quote_maturity_days;
  logic signed [27:0] in_quote_rate_micro_pct;
  logic [22:0]        in_query_day_q8;
  logic               out_valid;
  logic [31:0]        out_factor_q30;
  logic [1:0]         out_status;
  logic               cfg_we;
  logic               cfg_wdata;

  curve_scoreboard sb = new();
  int items = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int last_day;

  discount_curve_interpolator_top u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_command              (in_command),
    .in_quote_maturity_days  (in_quote_maturity_days),
    .in_quote_rate_micro_pct (in_quote_rate_micro_pct),
    .in_query_day_q8         (in_query_day_q8),
    .out_valid               (out_valid),
    .out_factor_q30          (out_factor_q30),
    .out_status              (out_status),
    .cfg_we                  (cfg_we),
    .cfg_wdata               (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_factor_q30, out_status);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(dci_pkg::cmd_t c, int d, int r, int t);
    start <= 1'b1;
    in_command <= c;
    in_quote_maturity_days <= 15'(d);
    in_quote_rate_micro_pct <= 28'(r);
    in_query_day_q8 <= 23'(t);
    do @(posedge clk); while (busy);
    sb.note(c, d & 32'h7FFF, r, t & 32'h7FFFFF);
    items++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(0, 8);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic drain_and_config(bit wr, bit v);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (wr) begin
      cfg_we <= 1'b1;
      cfg_wdata <= v;
      @(posedge clk);
      cfg_we <= 1'b0;
      sb.mode = v;
      @(posedge clk);
    end
  endtask

  function automatic int rand_rate();
    logic signed [27:0] v;
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return 0;
    if (k < 3) begin
      v = 28'($urandom);
      return int'(v);
    end
    return int'($urandom_range(0, 101000000)) - 1000000;
  endfunction

  task automatic directed(bit m);
    drain_and_config(1, m);
    send(dci_pkg::CMD_QUERY, 0, 0, 0);
    send(dci_pkg::CMD_QUERY, 0, 0, 23'h7FFFFF);
    send(dci_pkg::CMD_ADD, 50, 0, 0);
    send(dci_pkg::CMD_ADD, 0, 5, 0);
    send(dci_pkg::CMD_CLEAR, 0, 0, 0);
    send(dci_pkg::CMD_ADD, 30, 5000000, 0);
    send(dci_pkg::CMD_QUERY, 0, 0, 15 * 256 + 3);
    send(dci_pkg::CMD_ADD, 90, 100000000, 0);
    send(dci_pkg::CMD_ADD, 365, -1000000, 0);
    send(dci_pkg::CMD_ADD, 200, 7, 0);
    send(dci_pkg::CMD_ADD, 32767, -134217728, 0);
    send(dci_pkg::CMD_ADD, 32767, 134217727, 0);
    send(dci_pkg::CMD_QUERY, 0, 0, 30 * 256);
    send(dci_pkg::CMD_QUERY, 0, 0, 45 * 256 + 128);
    send(dci_pkg::CMD_QUERY, 0, 0, 365 * 256 + 1);
    send(dci_pkg::CMD_QUERY, 0, 0, 20000 * 256);
    send(dci_pkg::CMD_QUERY, 0, 0, 23'h7FFFFF);
    send(dci_pkg::CMD_NONE, 32767, -1, 23'h7FFFFF);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_command = dci_pkg::CMD_CLEAR;
    in_quote_maturity_days = '0;
    in_quote_rate_micro_pct = '0;
    in_query_day_q8 = '0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed(0);
    directed(1);
    while (items < 820) begin
      int n, q;
      drain_and_config($urandom_range(0, 1), $urandom_range(0, 1));
      send(dci_pkg::CMD_CLEAR, $urandom_range(0, 32767), rand_rate(),
           $urandom_range(0, 8388607));
      last_day = 0;
      n = $urandom_range(0, 4) == 0 ? $urandom_range(25, 34) : $urandom_range(1, 10);
      for (int k = 0; k < n; k++) begin
        int d;
        if ($urandom_range(0, 14) == 0) d = $urandom_range(0, 32767);
        else d = last_day + (n > 20 ? $urandom_range(1, 900) : $urandom_range(1, 3000));
        if (d > 32767) d = 32767;
        send(dci_pkg::CMD_ADD, d, rand_rate(), 0);
        last_day = int'(sb.day[sb.count - 1]);
      end
      q = $urandom_range(1, 15);
      for (int k = 0; k < q; k++) begin
        int t;
        case ($urandom_range(0, 9))
          0: t = $urandom_range(0, 8388607);
          1: t = int'(sb.day[$urandom_range(0, sb.count - 1)]) * 256;
          2: t = 0;
          default: t = $urandom_range(0, last_day * 256 + 600);
        endcase
        if ($urandom_range(0, 29) == 0)
          send(dci_pkg::CMD_NONE, $urandom_range(0, 32767), rand_rate(), t);
        else
          send(dci_pkg::CMD_QUERY, $urandom_range(0, 32767), rand_rate(), t);
      end
    end
    drain_and_config(0, 0);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
